>>> rtl/core/hsl_pkg.sv
// Package for the HSL to RGB duty converter: fixed-point constants and widths.
// Used by every module in rtl/core; depends on nothing.
package hsl_pkg;
	localparam int unsigned FracW = 16;
	localparam logic [15:0] ThirdQ16 = 16'd21845;
	localparam logic [15:0] SixthQ16 = 16'd10923;
	localparam logic [15:0] HalfQ16 = 16'd32768;
	localparam logic [15:0] TwoThirdsQ16 = 16'd43691;
	localparam logic [16:0] OneQ16 = 17'd65536;
	// The scaled operand reaches 16 * 65536, a 21-bit value, so the root
	// needs eleven digit steps and can reach 1024.
	localparam int unsigned SqrtSteps = 11;
	localparam int unsigned PipeDepth = 2 + SqrtSteps;
endpackage

>>> rtl/core/hsl_chan.sv
// One colour channel: intensity from p, q and hue offset, then root shaping.
// Depends on hsl_pkg. The pipeline registers move only when advance is high.
module hsl_chan import hsl_pkg::*; #(
	parameter int unsigned Scale16 = 1
) (
	input  logic        clk,
	input  logic        advance,
	input  logic [15:0] p,
	input  logic [15:0] q,
	input  logic [15:0] t,
	output logic [9:0]  duty
);
	localparam int unsigned RemW = 2 * SqrtSteps;

	// Stage 1: segment choice and the weight multiplier
	logic [15:0] d;
	logic [18:0] w;
	logic [1:0]  seg;
	logic [34:0] prod_s1;
	logic [15:0] p_s1;
	logic [15:0] q_s1;
	logic [1:0]  seg_s1;

	assign d = q - p;
	always_comb begin
		if (t < SixthQ16) begin
			seg = 2'd0;
			w = 19'(t) * 19'd6;
		end else if (t < HalfQ16) begin
			seg = 2'd1;
			w = '0;
		end else if (t < TwoThirdsQ16) begin
			seg = 2'd0;
			w = 19'(TwoThirdsQ16 - t) * 19'd6;
		end else begin
			seg = 2'd2;
			w = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= 35'(d) * 35'(w);
			p_s1 <= p;
			q_s1 <= q;
			seg_s1 <= seg;
		end
	end

	// Stage 2: intensity with saturation, then x = 1 - c
	logic [17:0] c;
	logic [16:0] c_sat;
	logic [RemW-1:0] x_s2;

	always_comb begin
		case (seg_s1)
			2'd0: c = 18'(p_s1) + 18'(prod_s1[34:16]);
			2'd1: c = 18'(q_s1);
			default: c = 18'(p_s1);
		endcase
		c_sat = (c > 18'(OneQ16)) ? OneQ16 : c[16:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (Scale16 != 0) x_s2 <= RemW'({OneQ16 - c_sat, 4'b0000});
			else x_s2 <= RemW'(OneQ16 - c_sat);
		end
	end

	// Square root stages: one result bit per stage, restoring method
	logic [RemW-1:0]      rem_v [SqrtSteps+1];
	logic [SqrtSteps-1:0] root_v [SqrtSteps+1];
	assign rem_v[0] = x_s2;
	assign root_v[0] = '0;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		localparam int unsigned Sh = 2 * (SqrtSteps - 1 - k);
		logic [RemW+1:0]      trial;
		logic [RemW-1:0]      rem_n;
		logic [SqrtSteps-1:0] root_n;
		always_comb begin
			trial = ((RemW+2)'(root_v[k]) << (Sh + 2)) | ((RemW+2)'(1) << Sh);
			if ((RemW+2)'(rem_v[k]) >= trial) begin
				rem_n = rem_v[k] - trial[RemW-1:0];
				root_n = (root_v[k] << 1) | SqrtSteps'(1);
			end else begin
				rem_n = rem_v[k];
				root_n = root_v[k] << 1;
			end
		end
		logic [RemW-1:0]      rem_q;
		logic [SqrtSteps-1:0] root_q;
		always_ff @(posedge clk) begin
			if (advance) begin
				rem_q <= rem_n;
				root_q <= root_n;
			end
		end
		assign rem_v[k+1] = rem_q;
		assign root_v[k+1] = root_q;
	end

	// A root of 1024 gives 1023, which still fits the ten-bit duty.
	assign duty = (root_v[SqrtSteps] == '0) ? '0 :
		10'(root_v[SqrtSteps] - SqrtSteps'(1));
endmodule

>>> rtl/core/hsl_to_rgb_sqrt_duty_unit.sv
// HSL to RGB converter with square-root shaping into inverted PWM duty values.
// One request on the input channel carries led_group, hue, lightness and
// saturation; one request on the output channel carries group_out and the
// three duty values red_duty, green_duty and blue_duty.
// The datapath is a pipeline of 14 register stages: one for p and q, one for
// the intensity multiply, one for saturation and 1 - c, and eleven restoring
// square-root stages of one result bit each. A request may enter every cycle
// in which in_ready is high.
// When the receiver stalls with a result waiting in the final stage, the
// whole pipeline holds, bubbles included, so nothing is lost or repeated;
// ready is high while the final stage is empty or is being taken.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// Depends on hsl_pkg and hsl_chan.
module hsl_to_rgb_sqrt_duty_unit import hsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       led_group,
	input  logic [7:0] hue,
	input  logic [7:0] lightness,
	input  logic [7:0] saturation,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       group_out,
	output logic [9:0] red_duty,
	output logic [9:0] green_duty,
	output logic [7:0] blue_duty
);
	localparam int unsigned Depth = PipeDepth + 1;

	logic [Depth-1:0] vld_q;
	logic [Depth-1:0] grp_q;
	logic             advance;

	// Simple global stall: move whenever the last stage is empty or taken.
	assign advance = !vld_q[Depth-1] || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) grp_q <= {grp_q[Depth-2:0], led_group};
	end

	// Stage 1 of the top level: p, q and hue offsets
	logic [15:0] p_s1, q_s1, tr_s1, tg_s1, tb_s1;
	logic [16:0] qn, pn;
	logic [15:0] hq;
	assign hq = {hue, 8'h00};
	always_comb begin
		if (lightness < 8'd128) begin
			qn = 17'(17'd256 * 17'(lightness) + 17'(lightness) * 17'(saturation));
			pn = 17'(17'(lightness) * (17'd256 - 17'(saturation)));
		end else begin
			qn = 17'(17'd256 * (17'(lightness) + 17'(saturation))
				- 17'(lightness) * 17'(saturation));
			pn = 17'(17'd256 * 17'(lightness) + 17'(lightness) * 17'(saturation)
				- 17'd256 * 17'(saturation));
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			q_s1 <= qn[15:0];
			p_s1 <= pn[15:0];
			tr_s1 <= hq + ThirdQ16;
			tg_s1 <= hq;
			tb_s1 <= hq - ThirdQ16;
		end
	end

	logic [9:0] r_d, g_d, b_d;
	hsl_chan #(.Scale16(1)) u_red (.clk, .advance, .p(p_s1), .q(q_s1), .t(tr_s1),
		.duty(r_d));
	hsl_chan #(.Scale16(1)) u_green (.clk, .advance, .p(p_s1), .q(q_s1), .t(tg_s1),
		.duty(g_d));
	hsl_chan #(.Scale16(0)) u_blue (.clk, .advance, .p(p_s1), .q(q_s1), .t(tb_s1),
		.duty(b_d));

	assign out_valid = vld_q[Depth-1];
	assign group_out = grp_q[Depth-1];
	assign red_duty = r_d;
	assign green_duty = g_d;
	assign blue_duty = b_d[7:0];
endmodule
